@@ rtl/core/max_weight_increasing_subsequence_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the increasing-subsequence block
// Two forms of clocked check: same-cycle implication and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef MAX_WEIGHT_INCREASING_SUBSEQUENCE_DEFINES_SVH
`define MAX_WEIGHT_INCREASING_SUBSEQUENCE_DEFINES_SVH

// Check that cons holds in any cycle in which ante holds.
`define MWIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after one in which ante holds.
`define MWIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/mwis_pkg.sv @@
// ----------------------------------------------------------------------------
// mwis_pkg
// Word layouts, fixed field widths and sequencer controls.
// ----------------------------------------------------------------------------
package mwis_pkg;

	localparam int KEY_W    = 11;
	localparam int WEIGHT_W = 32;
	localparam int BEST_W   = 42;
	localparam int RUN_W    = 41;

	typedef struct packed {
		logic [KEY_W-1:0]           key;
		logic signed [WEIGHT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic signed [BEST_W-1:0] best_ending_here;
		logic [RUN_W-1:0]         running_best;
	} result_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic clr;   // clearing pass: write zero
		logic start; // word accepted: capture weight, zero the prefix max
		logic acc;   // read data is a query node: fold into the prefix max
		logic add;   // form the sum ending here
		logic merge; // read data is an update node: write back the larger
		logic load;  // present the result word
	} ctl_t;

endpackage

@@ rtl/core/mwis_stream_if.sv @@
// ----------------------------------------------------------------------------
// mwis_stream_if
// Valid/ready channel carrying one word of a chosen type.
// ----------------------------------------------------------------------------
interface mwis_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mwis_ram.sv @@
// ----------------------------------------------------------------------------
// mwis_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mwis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/core/mwis_seq.sv @@
// ----------------------------------------------------------------------------
// mwis_seq
// Sequencer: clearing pass, tree walk addresses and datapath controls.
// ----------------------------------------------------------------------------
module mwis_seq #(
	parameter int KEY_RANGE = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [mwis_pkg::KEY_W-1:0]       key,
	output logic                             in_ready,
	input  logic                             out_free,
	output mwis_pkg::ctl_t                   ctl,
	output logic                             ram_re,
	output logic [$clog2(KEY_RANGE+1)-1:0]   ram_raddr,
	output logic                             ram_we,
	output logic [$clog2(KEY_RANGE+1)-1:0]   ram_waddr
);
	localparam int AW = $clog2(KEY_RANGE + 1);
	localparam int IW = ((AW > mwis_pkg::KEY_W) ? AW : mwis_pkg::KEY_W) + 1;
	localparam logic [IW-1:0] TOP  = IW'(KEY_RANGE);
	localparam logic [AW-1:0] LAST = AW'(KEY_RANGE);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_QUERY,
		S_ADD,
		S_UPDATE,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [IW-1:0]              idx_q;
	logic [mwis_pkg::KEY_W-1:0] key_q;
	logic [AW-1:0]              clr_q;
	logic [AW-1:0]              waddr_s1;
	logic                       acc_s1;
	logic                       upd_s1;

	logic [IW-1:0] lowbit;
	logic [IW-1:0] key_m1;
	logic [IW-1:0] q_start;
	logic [IW-1:0] u_start;
	logic          accept;
	logic          q_live;
	logic          u_live;

	always_comb begin
		lowbit  = idx_q & (~idx_q + IW'(1));
		key_m1  = IW'(key) - IW'(1);
		// query covers keys below this one, capped at the top of the range
		q_start = (key == '0) ? '0 : ((key_m1 > TOP) ? TOP : key_m1);
		// keys outside the range leave the tree alone
		u_start = ((key_q != '0) && (IW'(key_q) <= TOP)) ? IW'(key_q) : '0;
		accept  = in_valid && (state_q == S_IDLE);
		q_live  = (state_q == S_QUERY) && (idx_q != '0);
		u_live  = (state_q == S_UPDATE) && (idx_q != '0) && (idx_q <= TOP);

		in_ready  = (state_q == S_IDLE);
		ram_re    = q_live || u_live;
		ram_raddr = idx_q[AW-1:0];
		ram_we    = (state_q == S_CLEAR) || upd_s1;
		ram_waddr = (state_q == S_CLEAR) ? clr_q : waddr_s1;

		ctl.clr   = (state_q == S_CLEAR);
		ctl.start = accept;
		ctl.acc   = acc_s1;
		ctl.add   = (state_q == S_ADD);
		ctl.merge = upd_s1;
		ctl.load  = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			idx_q    <= '0;
			acc_s1   <= 1'b0;
			upd_s1   <= 1'b0;
			key_q    <= '0;
			waddr_s1 <= '0;
		end else begin
			acc_s1   <= q_live;
			upd_s1   <= u_live;
			waddr_s1 <= idx_q[AW-1:0];
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						key_q   <= key;
						idx_q   <= q_start;
						state_q <= S_QUERY;
					end
				end
				S_QUERY: begin
					// descend: strip the lowest set bit
					if (q_live) begin
						idx_q <= idx_q - lowbit;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					idx_q   <= u_start;
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					// ascend: add the lowest set bit
					if (u_live) begin
						idx_q <= idx_q + lowbit;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end
endmodule

@@ rtl/core/max_weight_increasing_subsequence.sv @@
// ----------------------------------------------------------------------------
// max_weight_increasing_subsequence
// Streaming maximum-weight strictly increasing subsequence over a max tree.
// ----------------------------------------------------------------------------
// Each input word carries a key and a signed weight; each yields one result
// word with the best sum of a strictly increasing subsequence ending at that
// item and the running maximum of all such sums (never below zero). The
// per-key maxima live in a binary indexed max tree of KEY_RANGE+1 entries held
// in one RAM with a single read and a single write port. One word at a time is
// processed: a query walk down the tree (one read per set bit of key-1,
// capped at KEY_RANGE), a step to form the sum, an update walk up the tree
// (one read per step, the merged value written back in the next cycle), then
// the result word. The sequencer holds a finished result while the output
// register is still full. After reset a clearing pass writes zero to every
// entry, during which no input word is taken. A finished result sits in an
// output register, so the next input word may be taken while it waits. Keys
// of zero or above KEY_RANGE are looked up but leave the tree unchanged.
// ----------------------------------------------------------------------------
`include "max_weight_increasing_subsequence_defines.svh"

module max_weight_increasing_subsequence #(
	parameter int KEY_RANGE = 1024
) (
	input logic         clk,
	input logic         arst_n,
	mwis_stream_if.sink   items,
	mwis_stream_if.source results
);
	localparam int AW    = $clog2(KEY_RANGE + 1);
	// sums are bounded by KEY_RANGE weights of at most 2^31
	localparam int SUM_W = $clog2(KEY_RANGE) + 32;

	mwis_pkg::ctl_t ctl;
	logic           in_ready;
	logic           out_free;
	logic           ram_re;
	logic           ram_we;
	logic [AW-1:0]  ram_raddr;
	logic [AW-1:0]  ram_waddr;

	logic signed [SUM_W-1:0] rdata;
	logic signed [SUM_W-1:0] wdata;
	logic signed [SUM_W-1:0] merged;
	logic signed [SUM_W-1:0] overall_nxt;

	logic signed [SUM_W-1:0]           best_q;
	logic signed [SUM_W-1:0]           here_q;
	logic signed [SUM_W-1:0]           overall_q;
	logic signed [mwis_pkg::WEIGHT_W-1:0] weight_q;
	mwis_pkg::result_t                 res_q;
	logic                              rvalid_q;

	// Sequencer: owns the tree walk and the clearing pass.
	mwis_seq #(
		.KEY_RANGE (KEY_RANGE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.key       (items.data.key),
		.in_ready  (in_ready),
		.out_free  (out_free),
		.ctl       (ctl),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr)
	);

	// Tree store: entry k holds the max over its subtree of per-key best sums.
	mwis_ram #(
		.WIDTH (SUM_W),
		.DEPTH (KEY_RANGE + 1)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_comb begin
		// read-modify-write: keep the larger of the node and the new sum
		merged      = (rdata > here_q) ? rdata : here_q;
		wdata       = ctl.clr ? '0 : merged;
		overall_nxt = (here_q > overall_q) ? here_q : overall_q;
		// output register frees up when empty or being drained this cycle
		out_free    = !rvalid_q || results.ready;
	end

	assign items.ready   = in_ready;
	assign results.valid = rvalid_q;
	assign results.data  = res_q;

	// Datapath payload: no reset needed.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			weight_q <= items.data.weight;
		end
		// prefix max starts at zero, as every stored entry does
		if (ctl.start) begin
			best_q <= '0;
		end else if (ctl.acc && (rdata > best_q)) begin
			best_q <= rdata;
		end
		if (ctl.add) begin
			here_q <= best_q + SUM_W'(weight_q);
		end
		if (ctl.load) begin
			res_q.best_ending_here <= mwis_pkg::BEST_W'(here_q);
			res_q.running_best     <= mwis_pkg::RUN_W'($unsigned(overall_nxt));
		end
	end

	// Running maximum and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				overall_q <= overall_nxt;
				rvalid_q  <= 1'b1;
			end else if (results.ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	// The walk never reads the entry it writes in the same cycle.
	`MWIS_ASSERT_NOW(a_no_rw_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr, "tree read and write hit one entry")
	// The running maximum never falls and never goes negative.
	`MWIS_ASSERT_NEXT(a_best_rises, clk, arst_n, 1'b1, (overall_q >= $past(overall_q)) && !overall_q[SUM_W-1], "running maximum fell")
	// No input word is taken while the tree is being cleared.
	`MWIS_ASSERT_NOW(a_clear_blocks, clk, arst_n, ctl.clr, !in_ready, "input taken during clearing pass")
	// A result is shown only once all tree traffic for it has drained.
	`MWIS_ASSERT_NOW(a_load_quiet, clk, arst_n, ctl.load, !ctl.acc && !ctl.merge && !ram_re, "result loaded with tree access in flight")
endmodule
